// ===== src/kdb_pkg.sv =====
// Shared types and constants for the key debounce block.
// Used by kdb_cell and key_debounce_short_long_press; depends on nothing.
package kdb_pkg;

    localparam int LEVEL_W  = 4;
    localparam int SETTLE_W = 8;
    localparam int HOLD_W   = 16;
    localparam int IDX_W    = 2;
    localparam int ACT_W    = 2;

    // Event codes.
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SHORT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LONG  = 2'd2;

    // Commands.
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ACTIVE_MASK = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [1:0] REG_LONG_LIMIT  = 2'd2;

    localparam logic [LEVEL_W-1:0]  ACTIVE_MASK_RST = 4'd0;
    localparam logic [SETTLE_W-1:0] DEBOUNCE_RST    = 8'd3;
    localparam logic [HOLD_W-1:0]   LONG_LIMIT_RST  = 16'd150;

    // Token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic [LEVEL_W-1:0] levels;
        logic               stop;
        logic [IDX_W-1:0]   who;
        logic [ACT_W-1:0]   act;
    } token_t;

    // Limits shared by every cell.
    typedef struct packed {
        logic [SETTLE_W-1:0] debounce_limit;
        logic [HOLD_W-1:0]   long_limit;
    } limits_t;

endpackage

// ===== src/key_debounce_short_long_press.sv =====
// Top level of the key debounce block: ports, configuration registers,
// the row of kdb_cell instances and the result buffer. Depends on kdb_pkg.
//
//  channel  | direction | tdata                        | tuser
//  s_       | in        | raw_levels [3:0], pad to 8   | command
//  m_       | out       | key_index [1:0], action [3:2]| -
//  APB      | in        | three registers at 0, 4, 8   | -
//
// An accepted item is registered at the entry of the row, the token then steps
// through the row of cells one key per cycle, and the result is registered at the output.
// One item is in the row at a time; the next is accepted once its token leaves the row.
// Reset is synchronous, active low, and sets all key states and configuration registers.
// A result that finds the output held waits in a spare buffer, and the input
// stays closed until that buffer drains; the row itself never stalls.
module key_debounce_short_long_press #(
    parameter int NUM_KEYS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] raw_levels, [7:4] zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] key_index, [3:2] action, [7:4] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [kdb_pkg::LEVEL_W-1:0]  mask_reg;
    logic [kdb_pkg::SETTLE_W-1:0] debounce_reg;
    logic [kdb_pkg::HOLD_W-1:0]   long_reg;
    kdb_pkg::limits_t             limits;

    kdb_pkg::token_t              tok [0:NUM_KEYS];
    kdb_pkg::token_t              entry_reg;
    logic [NUM_KEYS:0]            tok_valid;
    logic [NUM_KEYS-1:0]          key_lvl;
    logic [NUM_KEYS-1:0]          key_act;

    logic                         busy_reg;
    logic                         m_valid_reg;
    logic [3:0]                   m_data_reg;
    logic                         spare_valid_reg;
    logic [3:0]                   spare_data_reg;
    logic                         accept;
    logic                         done;
    logic                         cfg_wr;
    logic [3:0]                   result;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= kdb_pkg::ACTIVE_MASK_RST;
            debounce_reg <= kdb_pkg::DEBOUNCE_RST;
            long_reg     <= kdb_pkg::LONG_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                kdb_pkg::REG_ACTIVE_MASK: mask_reg     <= pwdata[kdb_pkg::LEVEL_W-1:0];
                kdb_pkg::REG_DEBOUNCE:    debounce_reg <= pwdata[kdb_pkg::SETTLE_W-1:0];
                kdb_pkg::REG_LONG_LIMIT:  long_reg     <= pwdata[kdb_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            kdb_pkg::REG_ACTIVE_MASK: prdata = {28'd0, mask_reg};
            kdb_pkg::REG_DEBOUNCE:    prdata = {24'd0, debounce_reg};
            kdb_pkg::REG_LONG_LIMIT:  prdata = {16'd0, long_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign limits.debounce_limit = debounce_reg;
    assign limits.long_limit     = long_reg;

    // Entry of the row.
    assign s_tready = !busy_reg && !spare_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= '{valid:  accept,
                           cmd:    s_tuser,
                           levels: s_tdata[kdb_pkg::LEVEL_W-1:0],
                           stop:   1'b0,
                           who:    '0,
                           act:    kdb_pkg::ACT_NONE};
        end
    end

    assign tok[0] = entry_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++) begin : g_cell
            // Keys above the input width see level zero and active level zero.
            if (g < kdb_pkg::LEVEL_W) begin : g_wired
                assign key_lvl[g] = tok[g].levels[g];
                assign key_act[g] = mask_reg[g];
            end else begin : g_absent
                assign key_lvl[g] = 1'b0;
                assign key_act[g] = 1'b0;
            end

            kdb_cell #(
                .KEY_IDX (g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok[g]),
                .lvl     (key_lvl[g]),
                .act_lvl (key_act[g]),
                .limits  (limits),
                .tok_out (tok[g+1])
            );
        end
        for (g = 0; g <= NUM_KEYS; g++) begin : g_valid
            assign tok_valid[g] = tok[g].valid;
        end
    endgenerate

    assign done   = tok[NUM_KEYS].valid;
    assign result = {tok[NUM_KEYS].act, tok[NUM_KEYS].who};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    // Output register with a spare slot for a result that finds it occupied.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_tready) begin
            if (done) begin
                spare_valid_reg <= 1'b1;
            end
        end else if (spare_valid_reg) begin
            m_valid_reg     <= 1'b1;
            spare_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_tready) begin
            if (done) begin
                spare_data_reg <= result;
            end
        end else if (spare_valid_reg) begin
            m_data_reg <= spare_data_reg;
        end else if (done) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg};

    // At most one item travels through the row of cells.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid))
        else $error("more than one token in the cell row");

    // An accepted item enters the row on the next cycle.
    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> tok[0].valid)
        else $error("accepted item did not enter the cell row");

    // A result without an event names key zero.
    a_no_event_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:2] == kdb_pkg::ACT_NONE) |-> m_tdata[1:0] == 2'd0)
        else $error("result without event carries a nonzero key index");

    // Nothing new is accepted while the spare slot holds a result.
    a_spare_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> !s_tready && !busy_reg)
        else $error("input open while spare result slot is full");

endmodule

// ===== src/kdb_cell.sv =====
// One key's debounce and press-timing state, updated when the token passes.
// Depends on kdb_pkg.
module kdb_cell #(
    parameter int KEY_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  kdb_pkg::token_t   tok_in,
    input  logic              lvl,
    input  logic              act_lvl,
    input  kdb_pkg::limits_t  limits,
    output kdb_pkg::token_t   tok_out
);

    localparam logic [kdb_pkg::IDX_W-1:0] IDX = kdb_pkg::IDX_W'(KEY_IDX);

    logic                           last_reg, last_next;
    logic                           stable_reg, stable_next;
    logic [kdb_pkg::SETTLE_W-1:0]   settle_reg, settle_next;
    logic [kdb_pkg::HOLD_W-1:0]     hold_reg, hold_next;
    logic                           pressed_reg, pressed_next;
    logic                           long_reg, long_next;
    kdb_pkg::token_t                tok_reg, tok_next;

    logic                           work;
    logic [kdb_pkg::ACT_W-1:0]      ev;
    logic [kdb_pkg::HOLD_W-1:0]     hold_inc;

    assign work = tok_in.valid && !tok_in.stop;
    assign hold_inc = (hold_reg < limits.long_limit) ? hold_reg + 1'b1 : hold_reg;

    always_comb begin
        last_next    = last_reg;
        stable_next  = stable_reg;
        settle_next  = settle_reg;
        hold_next    = hold_reg;
        pressed_next = pressed_reg;
        long_next    = long_reg;
        ev           = kdb_pkg::ACT_NONE;
        if (work) begin
            if (tok_in.cmd == kdb_pkg::CMD_INIT) begin
                last_next    = lvl;
                stable_next  = lvl;
                settle_next  = '0;
                hold_next    = '0;
                pressed_next = (lvl == act_lvl);
                long_next    = 1'b0;
            end else if (lvl != last_reg) begin
                last_next   = lvl;
                settle_next = '0;
            end else if (settle_reg < limits.debounce_limit) begin
                settle_next = settle_reg + 1'b1;
            end else if (lvl != stable_reg) begin
                stable_next = lvl;
                if (lvl == act_lvl) begin
                    pressed_next = 1'b1;
                end else begin
                    if (pressed_reg && !long_reg) begin
                        ev = kdb_pkg::ACT_SHORT;
                    end
                    pressed_next = 1'b0;
                end
                hold_next = '0;
                long_next = 1'b0;
            end else if (pressed_reg && !long_reg) begin
                hold_next = hold_inc;
                if (hold_inc >= limits.long_limit) begin
                    long_next = 1'b1;
                    ev        = kdb_pkg::ACT_LONG;
                end
            end
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (ev != kdb_pkg::ACT_NONE) begin
            tok_next.stop = 1'b1;
            tok_next.who  = IDX;
            tok_next.act  = ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= 1'b1;
            stable_reg  <= 1'b1;
            settle_reg  <= '0;
            hold_reg    <= '0;
            pressed_reg <= 1'b0;
            long_reg    <= 1'b0;
            tok_reg     <= '0;
        end else begin
            last_reg    <= last_next;
            stable_reg  <= stable_next;
            settle_reg  <= settle_next;
            hold_reg    <= hold_next;
            pressed_reg <= pressed_next;
            long_reg    <= long_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== test/key_debounce_short_long_press_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_short_long_press: a directed table,
// then random press and release sequences under several register settings.
// Depends on kdb_pkg and the key_debounce_short_long_press RTL.
module key_debounce_short_long_press_tb;

    localparam int KEYS = 4;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic                        cmd;
        logic [kdb_pkg::LEVEL_W-1:0] levels;
        logic [1:0]                  reg_idx;
        logic [kdb_pkg::HOLD_W-1:0]  reg_val;
        logic                        typed;
        logic [kdb_pkg::IDX_W-1:0]   exp_key;
        logic [kdb_pkg::ACT_W-1:0]   exp_act;
    } row_t;

    typedef struct packed {
        logic [kdb_pkg::IDX_W-1:0] key;
        logic [kdb_pkg::ACT_W-1:0] act;
    } key_event_t;

    // Default config is mask 0 (low level means pressed), debounce 3, long 150.
    localparam row_t DIRECTED [25] = '{
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b1, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_REG,  kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_DEBOUNCE,    16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_REG,  kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_LONG_LIMIT,  16'd2,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hE, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b1, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hE, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hE, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hE, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hD, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hD, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_INIT, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b1, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_REG,  kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'hF,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_REG,  kdb_pkg::CMD_SCAN, 4'h0, kdb_pkg::REG_LONG_LIMIT,  16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_INIT, 4'h0, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b1, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h8, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h8, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'h8, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_INIT, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b1, 2'd0, kdb_pkg::ACT_NONE},
        '{ROW_ITEM, kdb_pkg::CMD_SCAN, 4'hF, kdb_pkg::REG_ACTIVE_MASK, 16'd0,
          1'b0, 2'd0, kdb_pkg::ACT_NONE}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [3:0] raw_levels, [7:4] zero
    logic        s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [1:0] key_index, [3:2] action, [7:4] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Behavioral copy of the per-key debounce state and the registers.
    logic                         key_raw       [KEYS];
    logic                         key_stable    [KEYS];
    logic [kdb_pkg::SETTLE_W-1:0] key_settle    [KEYS];
    logic [kdb_pkg::HOLD_W-1:0]   key_hold      [KEYS];
    logic                         key_down      [KEYS];
    logic                         key_long_done [KEYS];
    logic [kdb_pkg::LEVEL_W-1:0]  act_mask;
    logic [kdb_pkg::SETTLE_W-1:0] db_limit;
    logic [kdb_pkg::HOLD_W-1:0]   lp_limit;

    key_event_t pending_events [$];

    int  errors = 0;
    int  n_items = 0;
    int  n_inits = 0;
    int  n_short = 0;
    int  n_long = 0;
    int  burst_left = 0;
    int  gap_len;
    bit  holdoff_req = 1'b0;
    int  holdoff_left = 0;
    int  ready_mode = 0;
    int  mode_left = 0;

    // Random press generator: per key target level, ticks left and bounce ticks.
    logic tgt_level   [KEYS];
    int   ticks_left  [KEYS];
    int   bounce_left [KEYS];

    key_debounce_short_long_press #(
        .NUM_KEYS(KEYS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("key_debounce_short_long_press test failed");
        $finish;
    end

    // Walks the keys in order for one item and returns the event it gives.
    task automatic debounce_scan(input logic cmd, input logic [kdb_pkg::LEVEL_W-1:0] lv,
                                 output key_event_t ev);
        int   i;
        logic lvl;
        logic on_lvl;
        logic stop;
        ev.key = '0;
        ev.act = kdb_pkg::ACT_NONE;
        stop = 1'b0;
        for (i = 0; i < KEYS && !stop; i++) begin
            lvl = lv[i];
            on_lvl = act_mask[i];
            if (cmd == kdb_pkg::CMD_INIT) begin
                key_raw[i] = lvl;
                key_stable[i] = lvl;
                key_settle[i] = '0;
                key_hold[i] = '0;
                key_down[i] = (lvl == on_lvl);
                key_long_done[i] = 1'b0;
            end else if (lvl != key_raw[i]) begin
                key_raw[i] = lvl;
                key_settle[i] = '0;
            end else if (key_settle[i] < db_limit) begin
                key_settle[i] = key_settle[i] + 1'b1;
            end else if (lvl != key_stable[i]) begin
                key_stable[i] = lvl;
                if (lvl == on_lvl) begin
                    key_down[i] = 1'b1;
                end else begin
                    // A release gives a short event only if no long event came first.
                    if (key_down[i] && !key_long_done[i]) begin
                        ev.key = kdb_pkg::IDX_W'(i);
                        ev.act = kdb_pkg::ACT_SHORT;
                    end
                    key_down[i] = 1'b0;
                end
                key_hold[i] = '0;
                key_long_done[i] = 1'b0;
            end else if (key_down[i] && !key_long_done[i]) begin
                if (key_hold[i] < lp_limit)
                    key_hold[i] = key_hold[i] + 1'b1;
                if (key_hold[i] >= lp_limit) begin
                    key_long_done[i] = 1'b1;
                    ev.key = kdb_pkg::IDX_W'(i);
                    ev.act = kdb_pkg::ACT_LONG;
                end
            end
            stop = (ev.act != kdb_pkg::ACT_NONE);
        end
    endtask

    // Offers one item in bursts with random gaps; the expectation is queued on accept.
    task automatic send_item(input logic cmd, input logic [kdb_pkg::LEVEL_W-1:0] lv,
                             input logic typed, input key_event_t typed_ev);
        key_event_t ev;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_len = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, lv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        debounce_scan(cmd, lv, ev);
        pending_events.push_back(typed ? typed_ev : ev);
        n_items++;
        if (cmd == kdb_pkg::CMD_INIT)
            n_inits++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (2 * (KEYS + 2)) @(posedge aclk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            kdb_pkg::REG_ACTIVE_MASK: act_mask = value[kdb_pkg::LEVEL_W-1:0];
            kdb_pkg::REG_DEBOUNCE:    db_limit = value[kdb_pkg::SETTLE_W-1:0];
            kdb_pkg::REG_LONG_LIMIT:  lp_limit = value[kdb_pkg::HOLD_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Mostly clean press/release sequences with bounce, plus noise and init items.
    task automatic run_phase(input logic [3:0] mask, input int db, input int lp,
                             input int count, input bit holdoff);
        int                          k;
        int                          j;
        int                          r;
        logic                        cmd;
        logic [kdb_pkg::LEVEL_W-1:0] lv;
        wait_drained();
        set_register(kdb_pkg::REG_ACTIVE_MASK, 32'(mask));
        set_register(kdb_pkg::REG_DEBOUNCE, 32'(db));
        set_register(kdb_pkg::REG_LONG_LIMIT, 32'(lp));
        for (j = 0; j < KEYS; j++) begin
            tgt_level[j] = ~mask[j];
            ticks_left[j] = $urandom_range(0, 4);
            bounce_left[j] = 0;
        end
        if (holdoff)
            holdoff_req = 1'b1;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            cmd = kdb_pkg::CMD_SCAN;
            lv = '0;
            // Noise would keep a long debounce from ever settling, so it is left out there.
            if (db < 16 && r < 3) begin
                cmd = kdb_pkg::CMD_INIT;
                lv = kdb_pkg::LEVEL_W'($urandom_range(0, 15));
            end else if (db < 16 && r < 12) begin
                lv = kdb_pkg::LEVEL_W'($urandom_range(0, 15));
            end else begin
                for (j = 0; j < KEYS; j++) begin
                    if (ticks_left[j] <= 0) begin
                        tgt_level[j] = ~tgt_level[j];
                        if (lp > 300 || $urandom_range(0, 1) == 0)
                            ticks_left[j] = $urandom_range(1, db + 3);
                        else
                            ticks_left[j] = $urandom_range(db + lp + 5, db + lp + 12);
                        bounce_left[j] = $urandom_range(0, 3);
                    end
                    lv[j] = (bounce_left[j] > 0) ? 1'($urandom_range(0, 1)) : tgt_level[j];
                    if (bounce_left[j] > 0)
                        bounce_left[j]--;
                    ticks_left[j]--;
                end
            end
            send_item(cmd, lv, 1'b0, '0);
        end
    endtask

    // Receiver: random ready patterns, and a long hold-off when the sender asks.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                holdoff_left = 120;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        key_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: result with nothing expected: key %0d action %0d",
                         $time, m_tdata[1:0], m_tdata[3:2]);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (m_tdata[1:0] !== want.key) begin
                    $display("%0t: key_index expected %0d got %0d",
                             $time, want.key, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[3:2] !== want.act) begin
                    $display("%0t: action expected %0d got %0d",
                             $time, want.act, m_tdata[3:2]);
                    errors++;
                end
                if (want.act == kdb_pkg::ACT_SHORT)
                    n_short++;
                else if (want.act == kdb_pkg::ACT_LONG)
                    n_long++;
            end
        end
    end

    initial begin
        int i;
        row_t row;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= kdb_pkg::CMD_SCAN;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        act_mask = kdb_pkg::ACTIVE_MASK_RST;
        db_limit = kdb_pkg::DEBOUNCE_RST;
        lp_limit = kdb_pkg::LONG_LIMIT_RST;
        for (i = 0; i < KEYS; i++) begin
            key_raw[i] = 1'b1;
            key_stable[i] = 1'b1;
            key_settle[i] = '0;
            key_hold[i] = '0;
            key_down[i] = 1'b0;
            key_long_done[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_REG) begin
                wait_drained();
                set_register(row.reg_idx, 32'(row.reg_val));
            end else begin
                send_item(row.cmd, row.levels, row.typed, '{row.exp_key, row.exp_act});
            end
        end

        run_phase(4'h0, 0, 1, 100, 1'b1);
        run_phase(4'hF, 1, 3, 100, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 2, 8, 100, 1'b1);
        run_phase(4'hA, 3, 20, 80, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 0, 65535, 60, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 255, 1, 260, 1'b0);
        run_phase(4'($urandom_range(0, 15)), $urandom_range(0, 5), $urandom_range(1, 16),
                  100, 1'b1);
        wait_drained();

        $display("Ran %0d items (%0d init) over seven register settings plus directed rows;",
                 n_items, n_inits);
        $display("checked %0d short and %0d long press events.", n_short, n_long);
        if (errors == 0)
            $display("key_debounce_short_long_press test passed");
        else
            $display("key_debounce_short_long_press test failed");
        $finish;
    end

endmodule

// ===== key_debounce_short_long_press.f =====
src/kdb_pkg.sv
src/kdb_cell.sv
src/key_debounce_short_long_press.sv
test/key_debounce_short_long_press_tb.sv
